### sv/bole_pkg.sv
// Shared types, widths and codes for the bounded ordered list engine.
// No dependencies; compile first.
package bole_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int AMT_W    = 8;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int FILL_W   = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_MOVE,
    S_PUT,
    S_DONE
  } state_t;

endpackage

### sv/bole_if.sv
// Command and result channel interfaces (valid/ready with payload).
// Depends on bole_pkg.
interface bole_in_if;
  import bole_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              command;
  value_t            value;
  logic [POS_W-1:0]  position;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output command, output value, output position,
                  output amount, input ready);
  modport sink   (input valid, input command, input value, input position,
                  input amount, output ready);
endinterface

interface bole_out_if;
  import bole_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  value_t             removed;
  logic [FOUND_W-1:0] found_index;
  logic [FILL_W-1:0]  fill;

  modport source (output valid, output status, output removed, output found_index,
                  output fill, input ready);
  modport sink   (input valid, input status, input removed, input found_index,
                  input fill, output ready);
endinterface

### sv/bounded_ordered_list_engine_unit.sv
// Bounded ordered list engine: top level with sequencer, two list banks and remainder unit.
// Depends on bole_pkg, bole_if, bole_ram and bole_rem.
//
// The block holds an ordered list of up to CAPACITY signed 32-bit entries in
// one of two RAM banks and works on one command beat at a time: insert at a
// 1-based position, delete at a position (the entry comes back in removed),
// search for the first filled entry equal to value, and rotate left by amount
// modulo the fill count. Each command beat yields exactly one result beat
// with a status and the fill count after the command. The cost of a command
// is set by the single read port of the active bank, one entry a cycle:
// a rejected command (full, empty, bad position) reads no entries; insert at
// position p reads the entries from p to the end, as does delete at p;
// search stops at the first match, or reads the whole list when nothing
// matches; rotate waits on the remainder unit and then copies the whole list.
// Rotation copies the list into the other bank and then swaps banks, so a
// rotation never moves an entry in place. A new command is taken once the previous
// result has been placed in the output register, even if that beat has not
// yet been taken downstream. There is no clearing pass after reset.
module bounded_ordered_list_engine_unit #(
  parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bole_in_if.sink    in_ch,
  bole_out_if.source out_ch
);
  import bole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  // control state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic                bank_r, bank_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // command context
  cmd_t                cmd_r, cmd_nxt;
  value_t              val_r, val_nxt;
  logic [AW-1:0]       put_addr_r, put_addr_nxt;
  logic [AW-1:0]       rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]       left_r, left_nxt;
  logic [AW-1:0]       dst_r, dst_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic                first_r, first_nxt;
  status_t             status_r, status_nxt;
  value_t              removed_r, removed_nxt;
  logic [AW-1:0]       found_r, found_nxt;

  // result register
  status_t             out_status_r, out_status_nxt;
  value_t              out_removed_r, out_removed_nxt;
  logic [FOUND_W-1:0]  out_found_r, out_found_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // RAM and remainder unit hookup
  logic                ram_we;
  logic                wr_bank;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  rdata0, rdata1, rdata;
  logic                rem_start;
  logic                rem_done;
  logic [CW-1:0]       rem_q;

  logic                accept;
  logic                issue;
  logic [XW-1:0]       pos_x, occ_x;
  logic [CW-1:0]       occ_new;

  assign accept = in_ch.valid && (state_r == S_IDLE);
  assign pos_x  = XW'(in_ch.position);
  assign occ_x  = XW'(occ_r);
  assign issue  = (left_r != '0);
  assign rdata  = bank_r ? rdata1 : rdata0;

  always_comb begin
    state_nxt       = state_r;
    occ_nxt         = occ_r;
    bank_nxt        = bank_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    cmd_nxt         = cmd_r;
    val_nxt         = val_r;
    put_addr_nxt    = put_addr_r;
    rd_addr_nxt     = rd_addr_r;
    left_nxt        = left_r;
    dst_nxt         = dst_r;
    pend_addr_nxt   = pend_addr_r;
    first_nxt       = first_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    found_nxt       = found_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_found_nxt   = out_found_r;
    out_fill_nxt    = out_fill_r;
    ram_we          = 1'b0;
    wr_bank         = bank_r;
    ram_waddr       = pend_addr_r;
    ram_wdata       = rdata;
    rem_start       = 1'b0;
    occ_new         = occ_r;
    in_ch.ready     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          cmd_nxt      = in_ch.command;
          val_nxt      = in_ch.value;
          removed_nxt  = '0;
          found_nxt    = '0;
          first_nxt    = 1'b1;
          pend_nxt     = 1'b0;
          dst_nxt      = '0;
          status_nxt   = ST_OK;
          put_addr_nxt = AW'(pos_x - XW'(1));
          unique case (in_ch.command)
            CMD_INSERT: begin
              // fullness first, then position
              if (occ_r >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (pos_x == '0 || pos_x > occ_x + XW'(1)) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_DONE;
              end else begin
                // move the tail up, last entry first
                rd_addr_nxt = AW'(occ_r - CW'(1));
                left_nxt    = CW'(occ_x - pos_x + XW'(1));
                state_nxt   = S_MOVE;
              end
            end
            CMD_DELETE: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else if (pos_x == '0 || pos_x > occ_x) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_DONE;
              end else begin
                // first beat read is the victim, the rest close the gap
                rd_addr_nxt = AW'(pos_x - XW'(1));
                left_nxt    = CW'(occ_x - pos_x + XW'(1));
                state_nxt   = S_MOVE;
              end
            end
            CMD_SEARCH: begin
              status_nxt  = ST_NOTFOUND;
              rd_addr_nxt = '0;
              left_nxt    = occ_r;
              state_nxt   = S_MOVE;
            end
            CMD_ROTATE: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                rem_start = 1'b1;
                state_nxt = S_REM;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_REM: begin
        // hold until the shift is known, then copy from it into the spare bank
        if (rem_done) begin
          rd_addr_nxt = AW'(rem_q);
          left_nxt    = occ_r;
          state_nxt   = S_MOVE;
        end
      end

      S_MOVE: begin
        if (issue) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_addr_r;
          left_nxt      = left_r - CW'(1);
          priority if (cmd_r == CMD_INSERT) begin
            rd_addr_nxt = rd_addr_r - AW'(1);
          end else if (cmd_r == CMD_ROTATE) begin
            if (CW'(rd_addr_r) == occ_r - CW'(1)) begin
              rd_addr_nxt = '0;
            end else begin
              rd_addr_nxt = rd_addr_r + AW'(1);
            end
          end else begin
            rd_addr_nxt = rd_addr_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          unique case (cmd_r)
            CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pend_addr_r + AW'(1);
            end
            CMD_DELETE: begin
              first_nxt = 1'b0;
              if (first_r) begin
                removed_nxt = rdata;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pend_addr_r - AW'(1);
              end
            end
            CMD_SEARCH: begin
              if (rdata == val_r) begin
                // first match wins: drop the rest of the pass
                status_nxt = ST_OK;
                found_nxt  = pend_addr_r;
                pend_nxt   = 1'b0;
                left_nxt   = '0;
                state_nxt  = S_DONE;
              end
            end
            CMD_ROTATE: begin
              ram_we    = 1'b1;
              wr_bank   = ~bank_r;
              ram_waddr = dst_r;
              dst_nxt   = dst_r + AW'(1);
            end
            default: begin
              ram_we = 1'b0;
            end
          endcase
        end

        if (!issue && !pend_r) begin
          state_nxt = (cmd_r == CMD_INSERT) ? S_PUT : S_DONE;
        end
      end

      S_PUT: begin
        // drop the new value into the opened slot
        ram_we    = 1'b1;
        ram_waddr = put_addr_r;
        ram_wdata = val_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (status_r == ST_OK) begin
          unique case (cmd_r)
            CMD_INSERT: occ_new = occ_r + CW'(1);
            CMD_DELETE: occ_new = occ_r - CW'(1);
            CMD_SEARCH: occ_new = occ_r;
            CMD_ROTATE: occ_new = occ_r;
            default:    occ_new = occ_r;
          endcase
        end
        // advance once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = removed_r;
          out_found_nxt   = FOUND_W'(found_r);
          out_fill_nxt    = FILL_W'(occ_new);
          occ_nxt         = occ_new;
          if (cmd_r == CMD_ROTATE && status_r == ST_OK) begin
            bank_nxt = ~bank_r;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      bank_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      bank_r      <= bank_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    val_r         <= val_nxt;
    put_addr_r    <= put_addr_nxt;
    rd_addr_r     <= rd_addr_nxt;
    left_r        <= left_nxt;
    dst_r         <= dst_nxt;
    pend_addr_r   <= pend_addr_nxt;
    first_r       <= first_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    found_r       <= found_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_fill_r    <= out_fill_nxt;
  end

  bole_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_bank0 (
    .clk   (clk),
    .we    (ram_we && !wr_bank),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (rdata0)
  );

  bole_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_bank1 (
    .clk   (clk),
    .we    (ram_we && wr_bank),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr_r),
    .rdata (rdata1)
  );

  bole_rem #(
    .CW (CW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (in_ch.amount),
    .divisor  (occ_r),
    .done     (rem_done),
    .rem      (rem_q)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.removed     = out_removed_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.fill        = out_fill_r;

endmodule

### sv/bole_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bole_rem.sv
// Restoring remainder unit: rotate amount modulo the fill count, one bit a cycle.
// Depends on bole_pkg.
module bole_rem #(
  parameter int CW = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bole_pkg::AMT_W-1:0] dividend,
  input  logic [CW-1:0]             divisor,
  output logic                      done,
  output logic [CW-1:0]             rem
);
  import bole_pkg::*;

  localparam int CNT_W = (AMT_W > 1) ? $clog2(AMT_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AMT_W-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]    dsr_r, dsr_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[AMT_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // bring down the next bit, subtract where it fits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = CW'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = CW'(trial);
      end
      dvd_nxt = {dvd_r[AMT_W-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(AMT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
